// ===== hdl/tabx_pkg.sv =====
// tabx_pkg: shared types and constants for the tab expander
// holds the request mode codes and the controller/datapath command and status structs
// no dependencies
package tabx_pkg;

   localparam int BYTE_W    = 8;
   localparam int MODE_W    = 2;
   localparam int STOP_IN_W = 12;
   localparam int SPACING_W = 11;
   localparam int COUNT_W   = 11;
   localparam int WORD_W    = 32;

   localparam logic [SPACING_W-1:0] SPACING_RESET = 11'd3;

   localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
   localparam logic [BYTE_W-1:0] CH_NL    = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;

   typedef enum logic [MODE_W-1:0] {
      MODE_CHAR  = 2'd0,
      MODE_SET   = 2'd1,
      MODE_CLEAR = 2'd2,
      MODE_RSVD  = 2'd3
   } mode_type;

   typedef struct packed {
      logic latch;
      logic load_stop_col;
      logic load_stop_max;
      logic load_stop_mod;
      logic load_stop_scan;
      logic mod_start;
      logic mod_step;
      logic scan_start;
      logic scan_next;
      logic set_read;
      logic set_write;
      logic clear_map;
      logic emit;
   } cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     is_tab;
      logic     col_past;
      logic     custom_used;
      logic     spacing_zero;
      logic     stop_ok;
      logic     mod_done;
      logic     scan_hit;
      logic     scan_last;
      logic     out_free;
   } status_type;

endpackage

// ===== hdl/tabx_stop_mem.sv =====
// tabx_stop_mem: tab stop bit map, one word of stops per row, registered read
// row valid flops make reset and clear take effect at once
// depends on tabx_pkg
module tabx_stop_mem #(
   parameter int ROWS  = 32,
   parameter int ROW_W = 5
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        clear,
   input  logic                        rd_en,
   input  logic [ROW_W-1:0]            rd_addr,
   output logic [tabx_pkg::WORD_W-1:0] rd_data,
   input  logic                        wr_en,
   input  logic [ROW_W-1:0]            wr_addr,
   input  logic [tabx_pkg::WORD_W-1:0] wr_data
);

   logic [tabx_pkg::WORD_W-1:0] mem_ff [ROWS];
   logic [tabx_pkg::WORD_W-1:0] rd_word_ff;
   logic [ROWS-1:0]             row_valid_ff;
   logic                        rd_live_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_word_ff <= mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         row_valid_ff <= '0;
         rd_live_ff   <= 1'b0;
      end else begin
         if (wr_en) begin
            row_valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_live_ff <= row_valid_ff[rd_addr];
         end
      end
   end

   // a row never written since the last clear reads as no stops
   assign rd_data = rd_live_ff ? rd_word_ff : '0;

endmodule

// ===== hdl/tabx_datapath.sv =====
// tabx_datapath: request latch, column tracking, spacing remainder unit,
// stop map scan and response register; depends on tabx_pkg and tabx_stop_mem
module tabx_datapath #(
   parameter int MAX_COLUMNS = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [tabx_pkg::MODE_W-1:0]       req_mode,
   input  logic [tabx_pkg::BYTE_W-1:0]       req_char_in,
   input  logic [tabx_pkg::STOP_IN_W-1:0]    req_stop_column,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [tabx_pkg::SPACING_W-1:0]    csr_default_spacing,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [tabx_pkg::BYTE_W-1:0]       rsp_out_byte,
   output logic [tabx_pkg::COUNT_W-1:0]      rsp_repeat_count,
   input  tabx_pkg::cmd_type                 cmd,
   output tabx_pkg::status_type              status
);

   localparam int WORD_W = tabx_pkg::WORD_W;
   localparam int SP_W   = tabx_pkg::SPACING_W;
   localparam int COL_W  = $clog2(MAX_COLUMNS + 2);
   localparam int SUM_W  = $clog2(MAX_COLUMNS + 2050);
   localparam int BIT_W  = $clog2(WORD_W);
   localparam int ROWS   = (MAX_COLUMNS + WORD_W - 1) / WORD_W;
   localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int CNT_W  = $clog2(COL_W + 1);

   localparam logic [COL_W-1:0] COL_MAX  = COL_W'(MAX_COLUMNS);
   localparam logic [COL_W-1:0] COL_END  = COL_W'(MAX_COLUMNS + 1);
   localparam logic [COL_W-1:0] COL_ONE  = COL_W'(1);
   localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
   localparam logic [SUM_W-1:0] SUM_MAX  = SUM_W'(MAX_COLUMNS);
   localparam logic [SUM_W-1:0] SUM_ONE  = SUM_W'(1);

   // request and configuration registers
   tabx_pkg::mode_type                 mode_ff;
   logic [tabx_pkg::BYTE_W-1:0]        char_ff;
   logic [tabx_pkg::STOP_IN_W-1:0]     stopin_ff;
   logic [SP_W-1:0]                    spacing_ff;

   // column state
   logic [COL_W-1:0] column_ff, column_in;
   logic [COL_W-1:0] stop_ff, stop_in;
   logic             custom_ff, custom_in;

   // remainder unit
   logic [SP_W:0]      rem_ff, rem_in;
   logic [COL_W-1:0]   shift_ff, shift_in;
   logic [CNT_W-1:0]   mod_cnt_ff, mod_cnt_in;
   logic [SP_W:0]      trial;
   logic [SP_W:0]      sp_ext;
   logic [SP_W-1:0]    rem_word;
   logic [SUM_W-1:0]   gap;
   logic [SUM_W-1:0]   mod_stop_w;
   logic [COL_W-1:0]   mod_stop;

   // map scan
   logic [ROW_W-1:0]   scan_row_ff, scan_row_in;
   logic               scan_first_ff, scan_first_in;
   logic [SUM_W-1:0]   col_m1, set_m1;
   logic [ROW_W-1:0]   col_row, set_row;
   logic [BIT_W-1:0]   col_bit, set_bit, hit_bit;
   logic [WORD_W-1:0]  low_mask, masked;
   logic [SUM_W-1:0]   scan_stop_w;
   logic               mem_rd_en;
   logic [ROW_W-1:0]   mem_rd_addr;
   logic [WORD_W-1:0]  mem_rd_data;
   logic [WORD_W-1:0]  mem_wr_data;

   // response
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [tabx_pkg::BYTE_W-1:0]   rsp_byte_ff;
   logic [tabx_pkg::COUNT_W-1:0]  rsp_count_ff;
   logic [SUM_W-1:0]              count_w;
   logic [COL_W-1:0]              advanced;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         spacing_ff <= tabx_pkg::SPACING_RESET;
      end else if (csr_valid) begin
         spacing_ff <= csr_default_spacing;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         mode_ff   <= tabx_pkg::mode_type'(req_mode);
         char_ff   <= req_char_in;
         stopin_ff <= req_stop_column;
      end
   end

   // ---------------- remainder of column by spacing, one bit a cycle
   assign sp_ext   = {1'b0, spacing_ff};
   assign trial    = {rem_ff[SP_W-1:0], shift_ff[COL_W-1]};
   assign rem_word = rem_ff[SP_W-1:0];
   assign gap      = SUM_W'(spacing_ff) - SUM_W'(rem_word);

   always_comb begin
      rem_in     = rem_ff;
      shift_in   = shift_ff;
      mod_cnt_in = mod_cnt_ff;
      if (cmd.mod_start) begin
         rem_in     = '0;
         shift_in   = column_ff;
         mod_cnt_in = CNT_W'(COL_W);
      end else if (cmd.mod_step) begin
         rem_in     = (trial >= sp_ext) ? trial - sp_ext : trial;
         shift_in   = {shift_ff[COL_W-2:0], 1'b0};
         mod_cnt_in = mod_cnt_ff - CNT_W'(1);
      end
   end

   // next multiple of spacing at or after the column, capped past the table
   always_comb begin
      mod_stop_w = (rem_word == '0) ? SUM_W'(column_ff) : SUM_W'(column_ff) + gap;
      mod_stop   = (mod_stop_w > SUM_MAX) ? COL_END : mod_stop_w[COL_W-1:0];
   end

   // ---------------- stop map access
   assign col_m1  = SUM_W'(column_ff) - SUM_ONE;
   assign col_row = col_m1[BIT_W +: ROW_W];
   assign col_bit = col_m1[BIT_W-1:0];
   assign set_m1  = SUM_W'(stopin_ff) - SUM_ONE;
   assign set_row = set_m1[BIT_W +: ROW_W];
   assign set_bit = set_m1[BIT_W-1:0];

   always_comb begin
      mem_rd_en = cmd.scan_start || cmd.scan_next || cmd.set_read;
      priority if (cmd.set_read) begin
         mem_rd_addr = set_row;
      end else if (cmd.scan_start) begin
         mem_rd_addr = col_row;
      end else begin
         mem_rd_addr = scan_row_ff + ROW_W'(1);
      end
   end

   always_comb begin
      scan_row_in   = scan_row_ff;
      scan_first_in = scan_first_ff;
      if (cmd.scan_start) begin
         scan_row_in   = col_row;
         scan_first_in = 1'b1;
      end else if (cmd.scan_next) begin
         scan_row_in   = scan_row_ff + ROW_W'(1);
         scan_first_in = 1'b0;
      end
   end

   // first row ignores stops left of the current column
   assign low_mask = (WORD_W'(1) << col_bit) - WORD_W'(1);
   assign masked   = mem_rd_data & (scan_first_ff ? ~low_mask : '1);

   always_comb begin
      hit_bit = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (masked[i]) begin
            hit_bit = BIT_W'(i);
         end
      end
   end

   assign scan_stop_w = SUM_W'({scan_row_ff, hit_bit}) + SUM_ONE;
   assign mem_wr_data = mem_rd_data | (WORD_W'(1) << set_bit);

   tabx_stop_mem #(
      .ROWS  (ROWS),
      .ROW_W (ROW_W)
   ) u_stop_mem (
      .clock   (clock),
      .reset   (reset),
      .clear   (cmd.clear_map),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (cmd.set_write),
      .wr_addr (set_row),
      .wr_data (mem_wr_data)
   );

   // ---------------- stop column, column and response
   always_comb begin
      priority if (cmd.load_stop_col) begin
         stop_in = column_ff;
      end else if (cmd.load_stop_max) begin
         stop_in = COL_END;
      end else if (cmd.load_stop_mod) begin
         stop_in = mod_stop;
      end else if (cmd.load_stop_scan) begin
         stop_in = scan_stop_w[COL_W-1:0];
      end else begin
         stop_in = stop_ff;
      end
   end

   assign count_w  = SUM_W'(stop_ff) - SUM_W'(column_ff) + SUM_ONE;
   assign advanced = (stop_ff == COL_END) ? COL_END : stop_ff + COL_ONE;

   always_comb begin
      column_in = column_ff;
      if (cmd.emit) begin
         column_in = (char_ff == tabx_pkg::CH_NL) ? COL_ONE : advanced;
      end
      custom_in = custom_ff;
      priority if (cmd.clear_map) begin
         custom_in = 1'b0;
      end else if (cmd.set_write) begin
         custom_in = 1'b1;
      end else begin
         custom_in = custom_ff;
      end
      rsp_valid_in = cmd.emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff     <= COL_ONE;
         custom_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         mod_cnt_ff    <= '0;
         rem_ff        <= '0;
         scan_first_ff <= 1'b0;
      end else begin
         column_ff     <= column_in;
         custom_ff     <= custom_in;
         rsp_valid_ff  <= rsp_valid_in;
         mod_cnt_ff    <= mod_cnt_in;
         rem_ff        <= rem_in;
         scan_first_ff <= scan_first_in;
      end
   end

   always_ff @(posedge clock) begin
      stop_ff     <= stop_in;
      shift_ff    <= shift_in;
      scan_row_ff <= scan_row_in;
      if (cmd.emit) begin
         rsp_byte_ff  <= (char_ff == tabx_pkg::CH_TAB) ? tabx_pkg::CH_SPACE : char_ff;
         rsp_count_ff <= count_w[tabx_pkg::COUNT_W-1:0];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_byte     = rsp_byte_ff;
   assign rsp_repeat_count = rsp_count_ff;

   always_comb begin
      status.mode         = mode_ff;
      status.is_tab       = (char_ff == tabx_pkg::CH_TAB);
      status.col_past     = (column_ff > COL_MAX);
      status.custom_used  = custom_ff;
      status.spacing_zero = (spacing_ff == '0);
      status.stop_ok      = (stopin_ff != '0) && (SUM_W'(stopin_ff) <= SUM_MAX);
      status.mod_done     = (mod_cnt_ff == '0);
      status.scan_hit     = |masked;
      status.scan_last    = (scan_row_ff == ROW_LAST);
      status.out_free     = !rsp_valid_ff || rsp_ready;
   end

   a_emit_loads: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid_ff)
      else $error("response not loaded after emit");

   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      cmd.load_stop_mod |-> (rem_ff < sp_ext))
      else $error("remainder not below spacing");

   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      cmd.load_stop_scan |-> (scan_stop_w >= SUM_W'(column_ff)) && (scan_stop_w <= SUM_MAX))
      else $error("scanned stop outside column range");

endmodule

// ===== hdl/tabx_ctrl.sv =====
// tabx_ctrl: sequencer for the tab expander
// decodes each request and steps the datapath through it; depends on tabx_pkg
module tabx_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  tabx_pkg::status_type  status,
   output tabx_pkg::cmd_type     cmd
);

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_DISPATCH = 6'b000010,
      ST_MOD      = 6'b000100,
      ST_SCAN     = 6'b001000,
      ST_SET      = 6'b010000,
      ST_EMIT     = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            unique case (status.mode)
               tabx_pkg::MODE_SET: begin
                  if (status.stop_ok) begin
                     cmd.set_read = 1'b1;
                     state_in     = ST_SET;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
               tabx_pkg::MODE_CLEAR: begin
                  cmd.clear_map = 1'b1;
                  state_in      = ST_IDLE;
               end
               tabx_pkg::MODE_CHAR: begin
                  state_in = ST_EMIT;
                  priority if (!status.is_tab || status.col_past) begin
                     cmd.load_stop_col = 1'b1;
                  end else if (status.custom_used) begin
                     cmd.scan_start = 1'b1;
                     state_in       = ST_SCAN;
                  end else if (status.spacing_zero) begin
                     cmd.load_stop_max = 1'b1;
                  end else begin
                     cmd.mod_start = 1'b1;
                     state_in      = ST_MOD;
                  end
               end
               tabx_pkg::MODE_RSVD: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_MOD: begin
            if (status.mod_done) begin
               cmd.load_stop_mod = 1'b1;
               state_in          = ST_EMIT;
            end else begin
               cmd.mod_step = 1'b1;
            end
         end
         ST_SCAN: begin
            priority if (status.scan_hit) begin
               cmd.load_stop_scan = 1'b1;
               state_in           = ST_EMIT;
            end else if (status.scan_last) begin
               // nothing left in the map: first column past the table
               cmd.load_stop_max = 1'b1;
               state_in          = ST_EMIT;
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         ST_SET: begin
            cmd.set_write = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("emit while response register is full");

   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_DISPATCH))
      else $error("accepted request not dispatched");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_next |-> !status.scan_last)
      else $error("scan ran past the last map row");

endmodule

// ===== hdl/tab_expander_with_stop_table.sv =====
// tab_expander_with_stop_table: top level, tabs to counted space runs
// depends on tabx_pkg, tabx_ctrl, tabx_datapath (with tabx_stop_mem)
//
//   channel  direction  ports                                            transfer
//   req      in         req_valid/ready, req_mode, req_char_in,           valid & ready
//                       req_stop_column
//   rsp      out        rsp_valid/ready, rsp_out_byte, rsp_repeat_count   valid & ready
//   csr      in         csr_valid/ready, csr_default_spacing              valid & ready
//
// one request at a time: a plain byte goes idle, dispatch, emit; a stop set goes idle,
// dispatch, set; a clear goes idle, dispatch. a tab with default stops runs the remainder
// unit before emit, one quotient bit per cycle; with custom stops it scans the map, one
// 32-column map row per cycle through the single read port
// reset is synchronous; the map is cleared at once by row valid bits, no sweep
// a full response register stalls the sequencer only once the next result is ready
module tab_expander_with_stop_table #(
   parameter int MAX_COLUMNS = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [tabx_pkg::MODE_W-1:0]       req_mode,
   input  logic [tabx_pkg::BYTE_W-1:0]       req_char_in,
   input  logic [tabx_pkg::STOP_IN_W-1:0]    req_stop_column,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [tabx_pkg::BYTE_W-1:0]       rsp_out_byte,
   output logic [tabx_pkg::COUNT_W-1:0]      rsp_repeat_count,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [tabx_pkg::SPACING_W-1:0]    csr_default_spacing
);

   tabx_pkg::cmd_type    cmd;
   tabx_pkg::status_type status;

   tabx_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tabx_datapath #(
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .req_mode            (req_mode),
      .req_char_in         (req_char_in),
      .req_stop_column     (req_stop_column),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_default_spacing (csr_default_spacing),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_repeat_count    (rsp_repeat_count),
      .cmd                 (cmd),
      .status              (status)
   );

endmodule

// ===== bench/tab_expander_with_stop_table_test.sv =====
// tab_expander_with_stop_table_test: self-checking bench for the tab expander
// walks a directed request table, then random text phases under several stop spacings
// depends on tabx_pkg and the tab_expander_with_stop_table rtl
module tab_expander_with_stop_table_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_COLUMNS   = 1024;
   localparam int SETTLE_CYCLES = 64;
   localparam int PHASE_ITEMS   = 95;

   localparam int BYTE_W    = tabx_pkg::BYTE_W;
   localparam int COUNT_W   = tabx_pkg::COUNT_W;
   localparam int STOP_IN_W = tabx_pkg::STOP_IN_W;
   localparam int SPACING_W = tabx_pkg::SPACING_W;

   localparam tabx_pkg::mode_type MODE_CHAR  = tabx_pkg::MODE_CHAR;
   localparam tabx_pkg::mode_type MODE_SET   = tabx_pkg::MODE_SET;
   localparam tabx_pkg::mode_type MODE_CLEAR = tabx_pkg::MODE_CLEAR;
   localparam tabx_pkg::mode_type MODE_RSVD  = tabx_pkg::MODE_RSVD;

   localparam logic [BYTE_W-1:0]    CH_TAB        = tabx_pkg::CH_TAB;
   localparam logic [BYTE_W-1:0]    CH_NL         = tabx_pkg::CH_NL;
   localparam logic [BYTE_W-1:0]    CH_SPACE      = tabx_pkg::CH_SPACE;
   localparam logic [SPACING_W-1:0] SPACING_RESET = tabx_pkg::SPACING_RESET;

   typedef struct packed {
      logic [BYTE_W-1:0]  out_byte;
      logic [COUNT_W-1:0] repeat_count;
   } detab_result_type;

   typedef enum logic {ROW_REQUEST, ROW_SPACING} row_kind_type;

   typedef struct packed {
      row_kind_type             kind;
      tabx_pkg::mode_type       mode;
      logic [BYTE_W-1:0]        char_in;
      logic [STOP_IN_W-1:0]     stop_column;
      logic [SPACING_W-1:0]     spacing;
      logic                     typed;
      logic [BYTE_W-1:0]        exp_byte;
      logic [COUNT_W-1:0]       exp_count;
   } stim_row_type;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_style_type;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   tabx_pkg::mode_type       req_mode;
   logic [BYTE_W-1:0]        req_char_in;
   logic [STOP_IN_W-1:0]     req_stop_column;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [BYTE_W-1:0]        rsp_out_byte;
   logic [COUNT_W-1:0]       rsp_repeat_count;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [SPACING_W-1:0]     csr_default_spacing;

   // predictor state
   bit                       stop_marks [0:MAX_COLUMNS];
   bit                       custom_on;
   int                       cur_column;
   logic [SPACING_W-1:0]     spacing_reg;

   detab_result_type         pending_results [$];
   int                       mismatch_count = 0;
   int                       gap_pct = 0;
   int                       stall_pct = 0;

   // expected values typed in only where they follow directly from reset state
   stim_row_type directed_rows [0:27] = '{
      '{ROW_REQUEST, MODE_CHAR,  8'h41,  12'd0,    11'd0, 1'b1, 8'h41,    11'd1},
      '{ROW_REQUEST, MODE_CHAR,  CH_TAB, 12'd0,    11'd0, 1'b1, CH_SPACE, 11'd2},
      '{ROW_REQUEST, MODE_CHAR,  CH_TAB, 12'd0,    11'd0, 1'b0, 8'h00,    11'd0},
      '{ROW_REQUEST, MODE_CHAR,  CH_NL,  12'd0,    11'd0, 1'b1, CH_NL,    11'd1},
      '{ROW_REQUEST, MODE_CHAR,  8'hFF,  12'hFFF,  11'd0, 1'b1, 8'hFF,    11'd1},
      '{ROW_REQUEST, MODE_CHAR,  8'h00,  12'd0,    11'd0, 1'b1, 8'h00,    11'd1},
      '{ROW_REQUEST, MODE_CHAR,  CH_TAB, 12'd0,    11'd0, 1'b0, 8'h00,    11'd0},
      // out-of-range stops must leave default spacing in force
      '{ROW_REQUEST, MODE_SET,   8'h00,  12'd0,    11'd0, 1'b0, 8'h00,    11'd0},
      '{ROW_REQUEST, MODE_SET,   8'hFF,  12'hFFF,  11'd0, 1'b0, 8'h00,    11'd0},
      '{ROW_REQUEST, MODE_SET,   8'h00,  12'd1025, 11'd0, 1'b0, 8'h00,    11'd0},
      '{ROW_REQUEST, MODE_CHAR,  CH_TAB, 12'd0,    11'd0, 1'b0, 8'h00,    11'd0},
      '{ROW_REQUEST, MODE_SET,   8'h00,  12'd1024, 11'd0, 1'b0, 8'h00,    11'd0},
      '{ROW_REQUEST, MODE_SET,   8'h00,  12'd10,   11'd0, 1'b0, 8'h00,    11'd0},
      '{ROW_REQUEST, MODE_CHAR,  CH_TAB, 12'd0,    11'd0, 1'b0, 8'h00,    11'd0},
      '{ROW_REQUEST, MODE_CHAR,  CH_TAB, 12'd0,    11'd0, 1'b0, 8'h00,    11'd0},
      // column now saturated past the table
      '{ROW_REQUEST, MODE_CHAR,  CH_TAB, 12'd0,    11'd0, 1'b1, CH_SPACE, 11'd1},
      '{ROW_REQUEST, MODE_CHAR,  8'h78,  12'd0,    11'd0, 1'b0, 8'h00,    11'd0},
      '{ROW_REQUEST, MODE_RSVD,  CH_TAB, 12'hFFF,  11'd0, 1'b0, 8'h00,    11'd0},
      '{ROW_REQUEST, MODE_CLEAR, 8'hFF,  12'hFFF,  11'd0, 1'b0, 8'h00,    11'd0},
      '{ROW_REQUEST, MODE_CHAR,  CH_TAB, 12'd0,    11'd0, 1'b1, CH_SPACE, 11'd1},
      '{ROW_REQUEST, MODE_CHAR,  CH_NL,  12'd0,    11'd0, 1'b1, CH_NL,    11'd1},
      '{ROW_REQUEST, MODE_SET,   8'h00,  12'd1,    11'd0, 1'b0, 8'h00,    11'd0},
      '{ROW_REQUEST, MODE_CHAR,  CH_TAB, 12'd0,    11'd0, 1'b0, 8'h00,    11'd0},
      '{ROW_REQUEST, MODE_CLEAR, 8'h00,  12'd0,    11'd0, 1'b0, 8'h00,    11'd0},
      // zero spacing: a tab from column 1 runs to the first column past the table
      '{ROW_SPACING, MODE_CHAR,  8'h00,  12'd0,    11'd0, 1'b0, 8'h00,    11'd0},
      '{ROW_REQUEST, MODE_CHAR,  CH_NL,  12'd0,    11'd0, 1'b1, CH_NL,    11'd1},
      '{ROW_REQUEST, MODE_CHAR,  CH_TAB, 12'd0,    11'd0, 1'b1, CH_SPACE, 11'd1025},
      '{ROW_REQUEST, MODE_CHAR,  CH_NL,  12'd0,    11'd0, 1'b1, CH_NL,    11'd1}
   };

   tab_expander_with_stop_table #(
      .MAX_COLUMNS (MAX_COLUMNS)
   ) i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_mode            (req_mode),
      .req_char_in         (req_char_in),
      .req_stop_column     (req_stop_column),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_repeat_count    (rsp_repeat_count),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_default_spacing (csr_default_spacing)
   );

   always #5 clock = ~clock;

   function automatic bit stop_at(input int col);
      if (col == 0 || col > MAX_COLUMNS) return 1'b1;
      if (custom_on) return stop_marks[col];
      if (spacing_reg == '0) return 1'b0;
      return (col % int'(spacing_reg)) == 0;
   endfunction

   function automatic void predict_request(input tabx_pkg::mode_type m,
                                           input logic [BYTE_W-1:0] ch,
                                           input logic [STOP_IN_W-1:0] sc, input bit typed,
                                           input detab_result_type typed_res);
      int               s;
      int               i;
      detab_result_type res;
      case (m)
         MODE_SET: begin
            if (sc != '0 && int'(sc) <= MAX_COLUMNS) begin
               stop_marks[int'(sc)] = 1'b1;
               custom_on = 1'b1;
            end
         end
         MODE_CLEAR: begin
            for (i = 0; i <= MAX_COLUMNS; i++) stop_marks[i] = 1'b0;
            custom_on = 1'b0;
         end
         MODE_CHAR: begin
            if (ch == CH_TAB) begin
               s = cur_column;
               while (!stop_at(s)) s++;
               res.out_byte = CH_SPACE;
               res.repeat_count = COUNT_W'(s - cur_column + 1);
               cur_column = (s > MAX_COLUMNS) ? MAX_COLUMNS + 1 : s + 1;
            end else if (ch == CH_NL) begin
               res.out_byte = CH_NL;
               res.repeat_count = COUNT_W'(1);
               cur_column = 1;
            end else begin
               res.out_byte = ch;
               res.repeat_count = COUNT_W'(1);
               cur_column = (cur_column > MAX_COLUMNS) ? MAX_COLUMNS + 1 : cur_column + 1;
            end
            pending_results.push_back(typed ? typed_res : res);
         end
         default: ;
      endcase
   endfunction

   task automatic send_request(input tabx_pkg::mode_type m, input logic [BYTE_W-1:0] ch,
                               input logic [STOP_IN_W-1:0] sc, input bit typed,
                               input detab_result_type typed_res);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_mode        <= m;
      req_char_in     <= ch;
      req_stop_column <= sc;
      do @(posedge clock); while (!req_ready);
      predict_request(m, ch, sc, typed, typed_res);
   endtask

   // spacing only changes with the block idle: drained, then a settle time for
   // a stop set or clear that has no result to wait for
   task automatic write_spacing(input logic [SPACING_W-1:0] value);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid           <= 1'b1;
      csr_default_spacing <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid   <= 1'b0;
      spacing_reg = value;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result byte %h count %0d", $time, rsp_out_byte,
                     rsp_repeat_count);
            mismatch_count++;
         end else begin
            detab_result_type exp_res;
            exp_res = pending_results.pop_front();
            if (rsp_out_byte !== exp_res.out_byte) begin
               $display("%0t: out_byte expected %h actual %h", $time, exp_res.out_byte,
                        rsp_out_byte);
               mismatch_count++;
            end
            if (rsp_repeat_count !== exp_res.repeat_count) begin
               $display("%0t: repeat_count expected %0d actual %0d", $time,
                        exp_res.repeat_count, rsp_repeat_count);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      int                   row;
      int                   phase;
      int                   n;
      int                   r;
      int                   set_pct;
      tabx_pkg::mode_type   m;
      logic [BYTE_W-1:0]    ch;
      logic [STOP_IN_W-1:0] sc;
      logic [SPACING_W-1:0] sp;
      idle_style_type       style;
      detab_result_type     typed_res;

      reset               = 1'b1;
      req_valid           = 1'b0;
      req_mode            = MODE_CHAR;
      req_char_in         = '0;
      req_stop_column     = '0;
      csr_valid           = 1'b0;
      csr_default_spacing = '0;
      for (n = 0; n <= MAX_COLUMNS; n++) stop_marks[n] = 1'b0;
      custom_on   = 1'b0;
      cur_column  = 1;
      spacing_reg = SPACING_RESET;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (row = 0; row < $size(directed_rows); row++) begin
         if (directed_rows[row].kind == ROW_SPACING) begin
            write_spacing(directed_rows[row].spacing);
         end else begin
            typed_res.out_byte     = directed_rows[row].exp_byte;
            typed_res.repeat_count = directed_rows[row].exp_count;
            send_request(directed_rows[row].mode, directed_rows[row].char_in,
                         directed_rows[row].stop_column, directed_rows[row].typed, typed_res);
         end
      end

      for (phase = 0; phase < 8; phase++) begin
         case (phase)
            0:       sp = SPACING_RESET;
            1:       sp = 11'd1;
            2:       sp = 11'd0;
            3:       sp = 11'd1024;
            4:       sp = 11'd2047;
            5:       sp = SPACING_W'($urandom_range(2, 12));
            6:       sp = SPACING_W'($urandom_range(1, 2047));
            default: sp = 11'd8;
         endcase
         write_spacing(sp);
         style = idle_style_type'(phase % 4);
         case (style)
            IDLE_SENDER:   begin gap_pct = 82; stall_pct = 0;  end
            IDLE_RECEIVER: begin gap_pct = 0;  stall_pct = 82; end
            IDLE_BOTH:     begin gap_pct = 14; stall_pct = 14; end
            default:       begin gap_pct = 0;  stall_pct = 0;  end
         endcase
         // odd phases lean on custom stops, even ones mostly on default spacing
         set_pct = (phase % 2 != 0) ? 10 : 1;
         for (n = 0; n < PHASE_ITEMS; n++) begin
            ch = ($urandom_range(9) < 6) ? BYTE_W'($urandom_range(32, 126))
                                         : BYTE_W'($urandom_range(255));
            r = $urandom_range(9);
            if (r < 7) begin
               sc = STOP_IN_W'($urandom_range(1, 80));
            end else if (r < 9) begin
               sc = STOP_IN_W'($urandom_range(4095));
            end else begin
               case ($urandom_range(4))
                  0:       sc = 12'd0;
                  1:       sc = 12'd1;
                  2:       sc = 12'd1024;
                  3:       sc = 12'd1025;
                  default: sc = 12'hFFF;
               endcase
            end
            r = $urandom_range(99);
            if (r < set_pct) begin
               m = MODE_SET;
            end else if (r < set_pct + 3) begin
               m = MODE_CLEAR;
            end else if (r < set_pct + 4) begin
               m = MODE_RSVD;
            end else begin
               m = MODE_CHAR;
               r = $urandom_range(99);
               if (r < 20) ch = CH_TAB;
               else if (r < 26) ch = CH_NL;
            end
            send_request(m, ch, sc, 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[tab_expander_with_stop_table] OK");
      end else begin
         $display("[tab_expander_with_stop_table] ERROR");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("[tab_expander_with_stop_table] ERROR");
      $finish;
   end

endmodule

// ===== tab_expander_with_stop_table.f =====
hdl/tabx_pkg.sv
hdl/tabx_stop_mem.sv
hdl/tabx_datapath.sv
hdl/tabx_ctrl.sv
hdl/tab_expander_with_stop_table.sv
bench/tab_expander_with_stop_table_test.sv
